[sv/i2c_mbs_pkg.sv]
// Package for the I2C master byte sequencer: action codes, step constants
// and the state and result structures. No dependencies.
package i2c_mbs_pkg;

  // Bus actions; the command field uses the same codes, zero meaning tick only.
  typedef enum logic [2:0] {
    ACT_IDLE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  localparam logic [3:0] StepFin  = 4'd15;
  localparam logic [3:0] ByteBits = 4'd8;
  localparam logic [7:0] TicksRst = 8'd5;

  // Register address map (word index).
  localparam logic RegPhaseTicks = 1'b0;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    action_e    action;
    logic [3:0] phase_step;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] tick_count;
    logic       scl;
    logic       sda;
    logic       drive;
    logic       ack;
    logic [7:0] rx_hold;
  } seq_state_t;

  // One result item.
  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } seq_res_t;

endpackage

[sv/i2c_mbs_step.sv]
// One tick of the I2C byte sequencer: next state and result from the
// current state and one registered item. Uses i2c_mbs_pkg.
module i2c_mbs_step import i2c_mbs_pkg::*; (
  input  seq_state_t state_i,
  input  logic [2:0] command_i,
  input  logic [7:0] tx_byte_i,
  input  logic       sda_in_i,
  input  logic [7:0] phase_ticks_i,
  output seq_state_t state_o,
  output seq_res_t   res_o
);

  seq_state_t s;
  logic       done;
  logic [3:0] nxt;

  always_comb begin
    s    = state_i;
    done = 1'b0;
    nxt  = 4'd0;

    // A command is taken only while idle; unknown codes act as tick only.
    if (s.action == ACT_IDLE && command_i >= 3'(ACT_START) &&
        command_i <= 3'(ACT_READ)) begin
      s.action     = action_e'(command_i);
      s.phase_step = 4'd0;
      s.bit_count  = 4'd0;
      s.tick_count = 8'd0;
      s.shift_reg  = (command_i == 3'(ACT_WRITE)) ? tx_byte_i : 8'd0;
    end

    if (s.action != ACT_IDLE) begin
      if (s.phase_step == StepFin) begin
        // Finishing tick: settle the lines and report completion.
        case (s.action)
          ACT_START: s.drive = 1'b0;
          ACT_STOP: begin
            s.scl   = 1'b0;
            s.drive = 1'b0;
          end
          ACT_WRITE: begin
            s.scl   = 1'b0;
            s.sda   = 1'b0;
            s.drive = 1'b0;
          end
          default: begin
            s.scl     = 1'b0;
            s.rx_hold = s.shift_reg;
          end
        endcase
        s.action     = ACT_IDLE;
        s.phase_step = 4'd0;
        s.bit_count  = 4'd0;
        s.tick_count = 8'd0;
        done         = 1'b1;
      end else begin
        // First tick of a segment changes the line levels.
        if (s.tick_count == 8'd0) begin
          case (s.action)
            ACT_START: begin
              if (s.phase_step == 4'd0) begin
                s.drive = 1'b1;
                s.sda   = 1'b1;
              end else if (s.phase_step == 4'd1) begin
                s.scl = 1'b1;
              end else if (s.phase_step == 4'd2) begin
                s.sda = 1'b0;
              end else begin
                s.scl = 1'b0;
              end
            end
            ACT_STOP: begin
              if (s.phase_step == 4'd0) begin
                s.drive = 1'b1;
                s.sda   = 1'b0;
              end else if (s.phase_step == 4'd1) begin
                s.scl = 1'b1;
              end else begin
                s.sda = 1'b1;
              end
            end
            ACT_WRITE: begin
              if (s.phase_step == 4'd0) begin
                s.scl   = 1'b0;
                s.drive = 1'b1;
                s.sda   = s.shift_reg[7];
              end else if (s.phase_step == 4'd1) begin
                s.scl = 1'b1;
              end else if (s.phase_step == 4'd2) begin
                s.scl   = 1'b0;
                s.drive = 1'b0;
                s.sda   = 1'b1;
              end else begin
                s.scl = 1'b1;
              end
            end
            default: begin
              if (s.phase_step == 4'd0) begin
                s.drive = 1'b0;
                s.sda   = 1'b1;
                s.scl   = 1'b1;
              end else if (s.phase_step == 4'd1) begin
                s.scl = 1'b0;
              end else if (s.phase_step == 4'd2) begin
                s.sda   = 1'b0;
                s.drive = 1'b1;
              end else begin
                s.scl = 1'b1;
              end
            end
          endcase
          s.tick_count = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
        end
        s.tick_count = s.tick_count - 8'd1;

        // Last tick of a segment samples the bus and picks the next step.
        if (s.tick_count == 8'd0) begin
          nxt = s.phase_step + 4'd1;
          case (s.action)
            ACT_START: begin
              if (s.phase_step >= 4'd3) nxt = StepFin;
            end
            ACT_STOP: begin
              if (s.phase_step >= 4'd2) nxt = StepFin;
            end
            ACT_WRITE: begin
              if (s.phase_step == 4'd1) begin
                s.shift_reg = {s.shift_reg[6:0], 1'b0};
                s.bit_count = s.bit_count + 4'd1;
                nxt         = (s.bit_count < ByteBits) ? 4'd0 : 4'd2;
              end else if (s.phase_step >= 4'd3) begin
                s.ack = ~sda_in_i;
                nxt   = StepFin;
              end
            end
            default: begin
              if (s.phase_step == 4'd0) begin
                s.shift_reg = {s.shift_reg[6:0], sda_in_i};
              end else if (s.phase_step == 4'd1) begin
                s.bit_count = s.bit_count + 4'd1;
                nxt         = (s.bit_count < ByteBits) ? 4'd0 : 4'd2;
              end else if (s.phase_step >= 4'd3) begin
                nxt = StepFin;
              end
            end
          endcase
          s.phase_step = nxt;
        end
      end
    end

    state_o         = s;
    res_o.scl       = s.scl;
    res_o.sda_level = s.sda;
    res_o.sda_drive = s.drive;
    res_o.busy      = (s.action != ACT_IDLE);
    res_o.done      = done;
    res_o.rx_byte   = s.rx_hold;
    res_o.ack_seen  = s.ack;
  end

endmodule

[sv/i2c_master_byte_sequencer_unit.sv]
// I2C master byte sequencer. Each input item is one timing tick carrying a
// command, a byte to send and the sampled data line; each item yields exactly
// one result item with the line levels, busy, done, the last received byte
// and the last ACK. One item is accepted every clock cycle unless a held result
// stalls the input; each item passes through the input register, then the
// one-tick step logic into the result register. The register phase_ticks (byte
// address 0) sets the ticks per bus delay step and may be written only while
// the block is idle. Depends on i2c_mbs_pkg and i2c_mbs_step.
module i2c_master_byte_sequencer_unit import i2c_mbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_o,
  output logic        sda_level_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        ack_seen_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_valid_q;
  logic [2:0] command_q;
  logic [7:0] tx_byte_q;
  logic       sda_in_q;
  logic       out_valid_q;
  logic       advance;
  logic [7:0] phase_ticks_q;
  seq_state_t state_q, state_d;
  seq_res_t   res_q, res_d;

  // Register interface.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPhaseTicks) ? {24'd0, phase_ticks_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= TicksRst;
    end else if (psel && penable && pwrite && paddr[2] == RegPhaseTicks) begin
      phase_ticks_q <= pwdata[7:0];
    end
  end

  // Handshake: the result register moves on when empty or taken.
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      command_q <= command_i;
      tx_byte_q <= tx_byte_i;
      sda_in_q  <= sda_in_i;
    end
  end

  // One tick of the sequencer.
  i2c_mbs_step u_step (
    .state_i       (state_q),
    .command_i     (command_q),
    .tx_byte_i     (tx_byte_q),
    .sda_in_i      (sda_in_q),
    .phase_ticks_i (phase_ticks_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  // Sequencer state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '{action: ACT_IDLE, default: '0};
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign scl_o       = res_q.scl;
  assign sda_level_o = res_q.sda_level;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign rx_byte_o   = res_q.rx_byte;
  assign ack_seen_o  = res_q.ack_seen;

endmodule

[sv/i2c_mbs_checker.sv]
// Port-level checks for the I2C master byte sequencer, bound to the top
// level. Depends on i2c_master_byte_sequencer_unit only through its ports.
module i2c_mbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [7:0]  rx_byte_o,
  input logic [31:0] prdata,
  input logic        pready
);

  // A finishing tick never reports the action as still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while busy");

  // Input side stalls only while a result waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A held result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o) &&
      $stable(done_res_o))
    else $error("held result changed");

  // Register port never stalls and reads only the defined bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && prdata[31:8] == 24'd0)
    else $error("register port misbehaves");

endmodule

bind i2c_master_byte_sequencer_unit i2c_mbs_checker u_i2c_mbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .rx_byte_o   (rx_byte_o),
  .prdata      (prdata),
  .pready      (pready)
);

[verif/i2c_master_byte_sequencer_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_byte_sequencer_unit: feeds timing ticks with random
// stalls, predicts every result item and compares it field by field.
// Depends on i2c_mbs_pkg and the sequencer RTL.
module i2c_master_byte_sequencer_unit_tb;
  import i2c_mbs_pkg::*;

  localparam logic [2:0] TicksAddr    = {RegPhaseTicks, 2'b00};
  localparam logic [2:0] UnusedAddr   = 3'd4;
  localparam logic [2:0] CmdTick      = 3'd0;
  localparam logic [2:0] CmdUnusedMin = 3'd5;
  localparam logic [2:0] CmdUnusedMax = 3'd7;
  localparam int SdaLow    = 0;
  localparam int SdaHigh   = 1;
  localparam int SdaRandom = 2;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned PhaseTicks  = 70;
  localparam int unsigned RandomPhases = 5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx;
    logic       sda;
  } tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CmdTick;
  logic [7:0]  tx_byte = 8'h00;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl, sda_level, sda_drive, busy_res, done_res, ack_seen;
  logic [7:0]  rx_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted bus state and configuration.
  action_e    bus_act = ACT_IDLE;
  logic [3:0] seg_step = 4'd0;
  logic [3:0] bits_done = 4'd0;
  logic [7:0] shifter = 8'h00;
  logic [7:0] seg_ticks = 8'h00;
  logic       scl_lvl = 1'b0;
  logic       sda_lvl = 1'b0;
  logic       sda_drv = 1'b0;
  logic       ack_lvl = 1'b0;
  logic [7:0] rx_last = 8'h00;
  logic [7:0] ticks_per_seg = TicksRst;

  tick_t       tick_queue[$];
  seq_res_t    line_results_q[$];
  bit          calm = 1'b0;
  int unsigned fault_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned pushed = 0;

  i2c_master_byte_sequencer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .tx_byte_i   (tx_byte),
    .sda_in_i    (sda_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .scl_o       (scl),
    .sda_level_o (sda_level),
    .sda_drive_o (sda_drive),
    .busy_res_o  (busy_res),
    .done_res_o  (done_res),
    .rx_byte_o   (rx_byte),
    .ack_seen_o  (ack_seen),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
    fault_count++;
  endtask

  // Advances the predicted sequencer by one tick and returns the line state after it.
  function automatic seq_res_t bus_tick(logic [2:0] cmd, logic [7:0] tx, logic sda);
    seq_res_t   res;
    logic [3:0] nxt;
    res = '0;
    // A command is only taken while idle; the unused codes act as plain ticks.
    if (bus_act == ACT_IDLE && cmd >= ACT_START && cmd <= ACT_READ) begin
      bus_act   = action_e'(cmd);
      seg_step  = 4'd0;
      bits_done = 4'd0;
      seg_ticks = 8'h00;
      shifter   = (cmd == ACT_WRITE) ? tx : 8'h00;
    end
    if (bus_act != ACT_IDLE) begin
      if (seg_step == StepFin) begin
        // Finishing tick: final line levels and the done pulse.
        case (bus_act)
          ACT_START: sda_drv = 1'b0;
          ACT_STOP: begin
            scl_lvl = 1'b0;
            sda_drv = 1'b0;
          end
          ACT_WRITE: begin
            scl_lvl = 1'b0;
            sda_lvl = 1'b0;
            sda_drv = 1'b0;
          end
          default: begin
            scl_lvl = 1'b0;
            rx_last = shifter;
          end
        endcase
        bus_act   = ACT_IDLE;
        seg_step  = 4'd0;
        bits_done = 4'd0;
        seg_ticks = 8'h00;
        res.done  = 1'b1;
      end else begin
        // Entering a segment sets the lines and reloads the tick count.
        if (seg_ticks == 8'h00) begin
          case (bus_act)
            ACT_START: begin
              if (seg_step == 4'd0) begin
                sda_drv = 1'b1;
                sda_lvl = 1'b1;
              end else if (seg_step == 4'd1) begin
                scl_lvl = 1'b1;
              end else if (seg_step == 4'd2) begin
                sda_lvl = 1'b0;
              end else begin
                scl_lvl = 1'b0;
              end
            end
            ACT_STOP: begin
              if (seg_step == 4'd0) begin
                sda_drv = 1'b1;
                sda_lvl = 1'b0;
              end else if (seg_step == 4'd1) begin
                scl_lvl = 1'b1;
              end else begin
                sda_lvl = 1'b1;
              end
            end
            ACT_WRITE: begin
              if (seg_step == 4'd0) begin
                scl_lvl = 1'b0;
                sda_drv = 1'b1;
                sda_lvl = shifter[7];
              end else if (seg_step == 4'd1) begin
                scl_lvl = 1'b1;
              end else if (seg_step == 4'd2) begin
                scl_lvl = 1'b0;
                sda_drv = 1'b0;
                sda_lvl = 1'b1;
              end else begin
                scl_lvl = 1'b1;
              end
            end
            default: begin
              if (seg_step == 4'd0) begin
                sda_drv = 1'b0;
                sda_lvl = 1'b1;
                scl_lvl = 1'b1;
              end else if (seg_step == 4'd1) begin
                scl_lvl = 1'b0;
              end else if (seg_step == 4'd2) begin
                sda_lvl = 1'b0;
                sda_drv = 1'b1;
              end else begin
                scl_lvl = 1'b1;
              end
            end
          endcase
          seg_ticks = (ticks_per_seg == 8'h00) ? 8'd1 : ticks_per_seg;
        end
        seg_ticks = seg_ticks - 8'd1;
        // The last tick of a segment samples the bus and picks the next step.
        if (seg_ticks == 8'h00) begin
          nxt = seg_step + 4'd1;
          case (bus_act)
            ACT_START: begin
              if (seg_step >= 4'd3) nxt = StepFin;
            end
            ACT_STOP: begin
              if (seg_step >= 4'd2) nxt = StepFin;
            end
            ACT_WRITE: begin
              if (seg_step == 4'd1) begin
                shifter   = shifter << 1;
                bits_done = bits_done + 4'd1;
                nxt       = (bits_done < ByteBits) ? 4'd0 : 4'd2;
              end else if (seg_step >= 4'd3) begin
                ack_lvl = ~sda;
                nxt     = StepFin;
              end
            end
            default: begin
              if (seg_step == 4'd0) begin
                shifter = {shifter[6:0], sda};
              end else if (seg_step == 4'd1) begin
                bits_done = bits_done + 4'd1;
                nxt       = (bits_done < ByteBits) ? 4'd0 : 4'd2;
              end else if (seg_step >= 4'd3) begin
                nxt = StepFin;
              end
            end
          endcase
          seg_step = nxt;
        end
      end
    end
    res.scl       = scl_lvl;
    res.sda_level = sda_lvl;
    res.sda_drive = sda_drv;
    res.busy      = (bus_act != ACT_IDLE);
    res.rx_byte   = rx_last;
    res.ack_seen  = ack_lvl;
    return res;
  endfunction

  // Driver: offers the next pending item and predicts each one that is accepted.
  always @(posedge clk_i) begin : drive_ticks
    tick_t nxt_item;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        line_results_q.push_back(bus_tick(command, tx_byte, sda_in));
      end
      if (!in_valid || in_ready) begin
        if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          nxt_item = tick_queue.pop_front();
          command  <= nxt_item.cmd;
          tx_byte  <= nxt_item.tx;
          sda_in   <= nxt_item.sda;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result item against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    seq_res_t got, want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = {scl, sda_level, sda_drive, busy_res, done_res, rx_byte, ack_seen};
        if (line_results_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 32'h0);
        end else begin
          want = line_results_q.pop_front();
          if (got.scl !== want.scl) begin
            report_mismatch("scl", 32'(got.scl), 32'(want.scl));
          end
          if (got.sda_level !== want.sda_level) begin
            report_mismatch("sda_level", 32'(got.sda_level), 32'(want.sda_level));
          end
          if (got.sda_drive !== want.sda_drive) begin
            report_mismatch("sda_drive", 32'(got.sda_drive), 32'(want.sda_drive));
          end
          if (got.busy !== want.busy) begin
            report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
          end
          if (got.done !== want.done) begin
            report_mismatch("done_res", 32'(got.done), 32'(want.done));
          end
          if (got.rx_byte !== want.rx_byte) begin
            report_mismatch("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
          end
          if (got.ack_seen !== want.ack_seen) begin
            report_mismatch("ack_seen", 32'(got.ack_seen), 32'(want.ack_seen));
          end
        end
      end
      out_ready <= calm || $urandom_range(99) >= 10;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_tick(logic [2:0] cmd, logic [7:0] tx, int sda_mode);
    tick_t t;
    t.cmd = cmd;
    t.tx  = tx;
    t.sda = (sda_mode == SdaRandom) ? 1'($urandom_range(1)) : 1'(sda_mode);
    tick_queue.push_back(t);
    pushed++;
  endtask

  // Ticks an action keeps the sequencer busy after its command tick.
  function automatic int unsigned action_ticks(action_e act, logic [7:0] rate);
    int unsigned segs;
    segs = (act == ACT_START) ? 4 : (act == ACT_STOP) ? 3 : 2 * ByteBits + 2;
    return segs * ((rate == 8'h00) ? 1 : rate);
  endfunction

  // Issues a command and follows it with ticks; noisy ticks carry stray commands.
  task automatic queue_action(action_e act, logic [7:0] tx, int sda_mode, bit noisy,
                              int unsigned follow);
    push_tick(act, tx, sda_mode);
    repeat (follow) begin
      push_tick((noisy && $urandom_range(7) == 0) ? 3'($urandom_range(7)) : CmdTick,
                8'($urandom), sda_mode);
    end
  endtask

  // Waits for every item and result to pass and for the sequencer to fall idle.
  task automatic settle();
    do begin
      while (tick_queue.size() != 0 || in_valid || line_results_q.size() != 0) begin
        @(posedge clk_i);
      end
      if (bus_act != ACT_IDLE) repeat (4) push_tick(CmdTick, 8'h00, SdaRandom);
    end while (bus_act != ACT_IDLE);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == TicksAddr) ticks_per_seg = value;
  endtask

  task automatic check_ticks_reg();
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= TicksAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'h0, ticks_per_seg}) begin
      report_mismatch("prdata", prdata, 32'(ticks_per_seg));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    action_e     act;
    int unsigned follow;
    int unsigned phase_start;
    int unsigned pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_ticks_reg();

    // At the reset rate: plain and unused commands while idle, then each action.
    push_tick(CmdTick, 8'h00, SdaLow);
    push_tick(CmdUnusedMin, 8'hFF, SdaHigh);
    push_tick(CmdUnusedMax, 8'h00, SdaLow);
    queue_action(ACT_START, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_START, ticks_per_seg));
    queue_action(ACT_WRITE, 8'hA5, SdaLow, 1'b0, action_ticks(ACT_WRITE, ticks_per_seg));
    // A write command landing during a read is ignored.
    queue_action(ACT_READ, 8'h00, SdaRandom, 1'b0, 3);
    queue_action(ACT_WRITE, 8'h5A, SdaRandom, 1'b0, action_ticks(ACT_READ, ticks_per_seg));
    queue_action(ACT_STOP, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_STOP, ticks_per_seg));
    settle();

    // Fastest rate: byte extremes, NACK and ACK, reads of all ones and all zeros.
    write_reg(TicksAddr, 8'd1);
    check_ticks_reg();
    queue_action(ACT_START, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_START, ticks_per_seg));
    queue_action(ACT_WRITE, 8'hFF, SdaHigh, 1'b0, action_ticks(ACT_WRITE, ticks_per_seg));
    queue_action(ACT_WRITE, 8'h00, SdaLow, 1'b0, action_ticks(ACT_WRITE, ticks_per_seg));
    queue_action(ACT_READ, 8'h00, SdaHigh, 1'b0, action_ticks(ACT_READ, ticks_per_seg));
    queue_action(ACT_READ, 8'hFF, SdaLow, 1'b0, action_ticks(ACT_READ, ticks_per_seg));
    queue_action(ACT_STOP, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_STOP, ticks_per_seg));
    settle();

    // A zero rate behaves as one tick per segment.
    write_reg(TicksAddr, 8'd0);
    check_ticks_reg();
    queue_action(ACT_START, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_START, ticks_per_seg));
    queue_action(ACT_WRITE, 8'($urandom), SdaRandom, 1'b0,
                 action_ticks(ACT_WRITE, ticks_per_seg));
    queue_action(ACT_READ, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_READ, ticks_per_seg));
    queue_action(ACT_STOP, 8'h00, SdaRandom, 1'b0, action_ticks(ACT_STOP, ticks_per_seg));
    settle();

    // A write beyond the register map is dropped; the largest rate reads back intact.
    write_reg(UnusedAddr, 8'd3);
    check_ticks_reg();
    write_reg(TicksAddr, 8'd255);
    check_ticks_reg();

    // Random phases: mostly whole actions, some cut short so the next command is ignored.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      write_reg(TicksAddr, (ph == 3) ? 8'($urandom_range(12, 5)) : 8'($urandom_range(4, 1)));
      check_ticks_reg();
      calm = (ph == 2);
      phase_start = pushed;
      while (pushed - phase_start < PhaseTicks) begin
        pick = $urandom_range(99);
        act = (pick < 15) ? ACT_START : (pick < 30) ? ACT_STOP :
              (pick < 65) ? ACT_WRITE : ACT_READ;
        follow = action_ticks(act, ticks_per_seg);
        if ($urandom_range(9) == 0) follow = $urandom_range(follow - 1);
        queue_action(act, 8'($urandom), SdaRandom, 1'b1, follow);
        repeat ($urandom_range(3)) begin
          push_tick(($urandom_range(3) == 0) ? 3'($urandom_range(CmdUnusedMax, CmdUnusedMin))
                                             : CmdTick, 8'($urandom), SdaRandom);
        end
      end
      settle();
      calm = 1'b0;
    end

    repeat (6) @(posedge clk_i);
    if (line_results_q.size() != 0) begin
      report_mismatch("results left over", 32'(line_results_q.size()), 32'd0);
    end
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/i2c_mbs_pkg.sv
sv/i2c_mbs_step.sv
sv/i2c_master_byte_sequencer_unit.sv
sv/i2c_mbs_checker.sv
verif/i2c_master_byte_sequencer_unit_tb.sv
